@@ rtl/pcpf_pkg.sv @@
package pcpf_pkg;

    // field counts and widths fixed by the item layout
    localparam int ROW_FIELDS = 4;
    localparam int VAL_W      = 8;
    localparam int OUT_IDX_W  = 4;

    // defaults for the top level parameters
    localparam int ROWS_DEFAULT = 4;
    localparam int COLS_DEFAULT = 16;

    typedef logic [ROW_FIELDS-1:0][VAL_W-1:0] t_col;

    typedef struct packed {
        logic [VAL_W-1:0] row0_value;
        logic [VAL_W-1:0] row1_value;
        logic [VAL_W-1:0] row2_value;
        logic [VAL_W-1:0] row3_value;
        logic             final_column;
    } t_in;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] earlier_index;
        logic [OUT_IDX_W-1:0] newer_index;
        logic                 run_end;
    } t_out;

    // per cell status seen by the top level
    typedef struct packed {
        logic live;  // token sits in this cell
        logic hit;   // stored column is a permutation of the request
        logic done;  // token reached the request's own index
        logic pass;  // token moves on to the next cell
    } t_cell_stat;

    // rows that take part in a comparison
    function automatic int used_rows(input int rows);
        used_rows = (rows < ROW_FIELDS) ? rows : ROW_FIELDS;
    endfunction

    // request fields to a column, unused rows forced to zero
    function automatic t_col col_from_in(input t_in d, input int used);
        t_col c;
        c[0] = d.row0_value;
        c[1] = d.row1_value;
        c[2] = d.row2_value;
        c[3] = d.row3_value;
        for (int r = 0; r < ROW_FIELDS; r++) begin
            if (r >= used) begin
                c[r] = '0;
            end
        end
        col_from_in = c;
    endfunction

    // same multiset of values, but not equal position by position
    function automatic logic perm_pair(input t_col a, input t_col b, input int used);
        logic [ROW_FIELDS-1:0] taken;
        logic                  differs;
        logic                  all_found;
        logic                  found;
        taken     = '0;
        differs   = 1'b0;
        all_found = 1'b1;
        for (int x = 0; x < ROW_FIELDS; x++) begin
            if (x < used && a[x] != b[x]) begin
                differs = 1'b1;
            end
        end
        for (int x = 0; x < ROW_FIELDS; x++) begin
            found = 1'b0;
            for (int y = 0; y < ROW_FIELDS; y++) begin
                if (x < used && y < used && !found && !taken[y] && a[x] == b[y]) begin
                    taken[y] = 1'b1;
                    found    = 1'b1;
                end
            end
            if (x < used && !found) begin
                all_found = 1'b0;
            end
        end
        perm_pair = differs && all_found;
    endfunction

endpackage

@@ rtl/pcpf_cell.sv @@
module pcpf_cell #(
    parameter int ROWS = 4,
    parameter int COLS = 16,
    parameter int K    = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_tok,
    input  pcpf_pkg::t_col             i_col,
    input  logic [$clog2(COLS)-1:0]    i_idx,
    output pcpf_pkg::t_cell_stat       o_stat
);
    import pcpf_pkg::*;

    localparam int              IW    = $clog2(COLS);
    localparam int              USED  = used_rows(ROWS);
    localparam logic [IW-1:0]   K_IDX = IW'(K);

    logic r_tok;
    logic n_tok;
    t_col r_store;
    logic at_end;
    logic earlier;

    // position of the token against the request's index
    assign at_end  = (K_IDX == i_idx);
    assign earlier = (K_IDX < i_idx);

    assign o_stat.live = r_tok;
    assign o_stat.hit  = r_tok && earlier && perm_pair(r_store, i_col, USED);
    assign o_stat.done = r_tok && at_end;
    assign o_stat.pass = r_tok && !at_end;

    // token moves one cell per advancing cycle
    assign n_tok = i_adv ? i_tok : r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // the column lands in its own cell when the token arrives there
    always_ff @(posedge i_clk) begin
        if (i_adv && r_tok && at_end) begin
            r_store <= i_col;
        end
    end

endmodule

@@ rtl/permuted_column_pair_finder_unit.sv @@
// scan: a column at index n is scanned by the token from cell 0 up to cell n
// each pair waits for the next hit or the end of the scan, then takes the output
// register; the last pair of a column goes out when its scan ends
// input: the next column is taken once the token has left the chain of cells;
// output stalls hold the chain and so hold off the next column
// reset: synchronous, active low, clears the column count, token and valids only
module permuted_column_pair_finder_unit #(
    parameter int ROWS = pcpf_pkg::ROWS_DEFAULT,
    parameter int COLS = pcpf_pkg::COLS_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pcpf_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output pcpf_pkg::t_out  o_out_data
);
    import pcpf_pkg::*;

    localparam int            IW    = $clog2(COLS);
    localparam int            USED  = used_rows(ROWS);
    localparam logic [IW-1:0] LAST  = IW'(COLS - 1);

    t_cell_stat          stat [COLS];
    logic [COLS-1:0]     tok_in;

    logic [IW-1:0]       r_count;
    logic [IW-1:0]       r_idx;
    t_col                r_col;
    logic                r_pend_valid;
    logic [IW-1:0]       r_pend_e;
    logic [IW-1:0]       r_pend_n;
    logic                r_out_valid;
    t_out                r_out;

    logic                busy;
    logic                hit_any;
    logic                done_any;
    logic [IW-1:0]       hit_e;
    logic                out_free;
    logic                adv;
    logic                push;
    logic                accept;
    logic                last;

    // gather status of the chain
    always_comb begin
        busy     = 1'b0;
        hit_any  = 1'b0;
        done_any = 1'b0;
        hit_e    = '0;
        for (int k = 0; k < COLS; k++) begin
            busy     = busy | stat[k].live;
            hit_any  = hit_any | stat[k].hit;
            done_any = done_any | stat[k].done;
            if (stat[k].hit) begin
                hit_e = hit_e | IW'(k);
            end
        end
    end

    // the chain holds while a pending result has nowhere to go
    assign out_free = !r_out_valid || i_out_ready;
    assign push     = r_pend_valid && (hit_any || done_any);
    assign adv      = !push || out_free;
    assign accept   = i_in_valid && o_in_ready;
    assign last     = i_in_data.final_column || (r_count == LAST);

    assign o_in_ready  = !busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // token chain
    assign tok_in[0] = accept;
    for (genvar k = 1; k < COLS; k++) begin : g_link
        assign tok_in[k] = stat[k-1].pass;
    end

    for (genvar k = 0; k < COLS; k++) begin : g_cell
        pcpf_cell #(
            .ROWS (ROWS),
            .COLS (COLS),
            .K    (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tok   (tok_in[k]),
            .i_col   (r_col),
            .i_idx   (r_idx),
            .o_stat  (stat[k])
        );
    end

    // request capture and column count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= last ? '0 : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col <= col_from_in(i_in_data, USED);
            r_idx <= r_count;
        end
    end

    // one result held back until the next hit or the end of the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (adv && hit_any) begin
            r_pend_valid <= 1'b1;
        end else if (adv && done_any) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && hit_any) begin
            r_pend_e <= hit_e;
            r_pend_n <= r_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push && adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && adv) begin
            r_out.earlier_index <= OUT_IDX_W'(r_pend_e);
            r_out.newer_index   <= OUT_IDX_W'(r_pend_n);
            r_out.run_end       <= done_any;
        end
    end

endmodule

@@ verif/tb_permuted_column_pair_finder_unit.sv @@
module tb_permuted_column_pair_finder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pcpf_pkg::*;

    localparam int ROWS          = ROWS_DEFAULT;
    localparam int COLS          = COLS_DEFAULT;
    localparam int N_ROWS        = (ROWS < ROW_FIELDS) ? ROWS : ROW_FIELDS;
    localparam int RANDOM_ITEMS  = 205;
    localparam int CALM_ITEMS    = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out_data;

    // pacing controls shared by the driving processes
    bit hold_request = 1'b0;
    bit calm         = 1'b0;
    int cycle_count  = 0;

    // tracks the stored columns and the pairs still owed by the block
    class pair_scoreboard;
        t_col        columns [COLS];
        int unsigned next_index;
        t_out        pending_pairs [$];
        int          mismatches;

        function new();
            next_index = 0;
            mismatches = 0;
        endfunction

        // same values in some order, but not the same column
        function bit is_permutation(t_col a, t_col b);
            logic [VAL_W-1:0] sorted_a [ROW_FIELDS];
            logic [VAL_W-1:0] sorted_b [ROW_FIELDS];
            logic [VAL_W-1:0] t;
            if (a == b) begin
                return 1'b0;
            end
            for (int r = 0; r < ROW_FIELDS; r++) begin
                sorted_a[r] = a[r];
                sorted_b[r] = b[r];
            end
            for (int i = 0; i < ROW_FIELDS - 1; i++) begin
                for (int j = 0; j < ROW_FIELDS - 1 - i; j++) begin
                    if (sorted_a[j] > sorted_a[j+1]) begin
                        t = sorted_a[j]; sorted_a[j] = sorted_a[j+1]; sorted_a[j+1] = t;
                    end
                    if (sorted_b[j] > sorted_b[j+1]) begin
                        t = sorted_b[j]; sorted_b[j] = sorted_b[j+1]; sorted_b[j+1] = t;
                    end
                end
            end
            return sorted_a == sorted_b;
        endfunction

        // store the new column and queue its pairs against earlier columns
        function void note_request(t_in d);
            t_col        c;
            int unsigned idx;
            bit          last;
            t_out        hits [$];
            t_out        p;
            idx  = (next_index >= COLS) ? 0 : next_index;
            c[0] = d.row0_value;
            c[1] = d.row1_value;
            c[2] = d.row2_value;
            c[3] = d.row3_value;
            for (int r = N_ROWS; r < ROW_FIELDS; r++) begin
                c[r] = '0;
            end
            last = d.final_column || (idx == COLS - 1);
            for (int e = 0; e < idx; e++) begin
                if (is_permutation(columns[e], c)) begin
                    p.earlier_index = e[OUT_IDX_W-1:0];
                    p.newer_index   = idx[OUT_IDX_W-1:0];
                    p.run_end       = 1'b0;
                    hits.push_back(p);
                end
            end
            if (hits.size() > 0) begin
                hits[hits.size()-1].run_end = 1'b1;
            end
            foreach (hits[k]) begin
                pending_pairs.push_back(hits[k]);
            end
            columns[idx] = c;
            next_index   = last ? 0 : idx + 1;
        endfunction

        // compare one reported pair with the oldest one owed
        function void check_result(t_out got);
            t_out want;
            if (pending_pairs.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected pair: earlier %0d newer %0d run_end %0b",
                             got.earlier_index, got.newer_index, got.run_end);
                end
                return;
            end
            want = pending_pairs.pop_front();
            if (got.earlier_index != want.earlier_index ||
                got.newer_index != want.newer_index ||
                got.run_end != want.run_end) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("pair mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                             want.earlier_index, want.newer_index, want.run_end,
                             got.earlier_index, got.newer_index, got.run_end);
                end
            end
        endfunction
    endclass

    pair_scoreboard pair_checker;

    permuted_column_pair_finder_unit #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // watch both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pair_checker.note_request(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                pair_checker.check_result(o_out_data);
            end
        end
    end

    // result side: random stall bursts, one long hold-off, none at the end
    initial begin
        int stall_pct;
        int hold_left;
        i_out_ready <= 1'b0;
        stall_pct = 25;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
            if ($urandom_range(0, 49) == 0) begin
                stall_pct = $urandom_range(0, 2) * 25;
            end
        end
    end

    function automatic t_in make_col(logic [7:0] r0, logic [7:0] r1, logic [7:0] r2,
                                     logic [7:0] r3, logic fin);
        t_in d;
        d.row0_value   = r0;
        d.row1_value   = r1;
        d.row2_value   = r2;
        d.row3_value   = r3;
        d.final_column = fin;
        return d;
    endfunction

    // offer one request, with an optional idle burst ahead of it
    task automatic send_column(input t_in d, input int gap_pct);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // fixed corner cases
    task automatic run_directed();
        logic [7:0] vals [4];
        int         count;
        vals  = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        count = 0;
        // sixteen distinct orderings of one set: overflow ends the matrix,
        // the last column pairs with all fifteen before it
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                for (int c = 0; c < 4; c++) begin
                    for (int e = 0; e < 4; e++) begin
                        if (a != b && a != c && a != e && b != c && b != e && c != e &&
                            count < COLS) begin
                            send_column(make_col(vals[a], vals[b], vals[c], vals[e], 1'b0), 25);
                            count++;
                        end
                    end
                end
            end
        end
        // identical column, reversed column, repeated values, early final
        send_column(make_col(8'd1, 8'd2, 8'd3, 8'd4, 1'b0), 25);
        send_column(make_col(8'd1, 8'd2, 8'd3, 8'd4, 1'b0), 25);
        send_column(make_col(8'd4, 8'd3, 8'd2, 8'd1, 1'b0), 25);
        send_column(make_col(8'd7, 8'd7, 8'd9, 8'd9, 1'b0), 25);
        send_column(make_col(8'd9, 8'd7, 8'd7, 8'd9, 1'b0), 25);
        send_column(make_col(8'd7, 8'd9, 8'd9, 8'd9, 1'b0), 25);
        send_column(make_col(8'd9, 8'd9, 8'd7, 8'd7, 1'b1), 25);
        // fresh matrix sees nothing from the last one
        send_column(make_col(8'd9, 8'd9, 8'd7, 8'd7, 1'b0), 25);
        send_column(make_col(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 25);
    endtask

    // random matrices, mostly orderings of one base set per matrix
    task automatic run_random();
        int   sent;
        int   len;
        int   kind;
        int   gap_pct;
        int   pick;
        int   j;
        bit   overflow;
        t_col base;
        t_col c;
        logic [7:0] t;
        sent = 0;
        hold_request = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            len      = ($urandom_range(0, 4) == 0) ? COLS : $urandom_range(1, 8);
            overflow = (len == COLS) && ($urandom_range(0, 1) == 1);
            kind     = $urandom_range(0, 3);
            gap_pct  = $urandom_range(0, 2) * 20;
            case ($urandom_range(0, 2))
                0: base = $urandom;
                1: for (int r = 0; r < ROW_FIELDS; r++) base[r] = 8'($urandom_range(0, 3));
                default: begin
                    base[0] = 8'($urandom); base[1] = base[0];
                    base[2] = 8'($urandom); base[3] = $urandom_range(0, 1) ? base[2] : base[0];
                end
            endcase
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 9);
                if (kind == 0 || pick == 1) begin
                    // noise column
                    for (int r = 0; r < ROW_FIELDS; r++) begin
                        c[r] = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                    : 8'($urandom_range(0, 255));
                    end
                end else if (pick == 0) begin
                    c = base;
                end else begin
                    // shuffled base
                    c = base;
                    for (int r = ROW_FIELDS - 1; r > 0; r--) begin
                        j    = $urandom_range(0, r);
                        t    = c[r];
                        c[r] = c[j];
                        c[j] = t;
                    end
                end
                send_column(make_col(c[0], c[1], c[2], c[3],
                                     (k == len - 1) && !overflow), gap_pct);
                sent++;
                if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
                    calm = 1'b1;
                end
            end
        end
    endtask

    // main sequence
    initial begin
        pair_checker = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pair_checker.pending_pairs.size() != 0) @(posedge i_clk);
        repeat (2 * COLS + 8) @(posedge i_clk);
        if (pair_checker.mismatches == 0 && pair_checker.pending_pairs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
